>>> rtl/core/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, codes and defaults of the counting semaphore table unit.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int NUM_SEMS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PID_BITS_DEF    = 8;

  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_WAIT    = 2'd1,
    OP_POST    = 2'd2,
    OP_DESTROY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_INVALID    = 2'd1,
    ST_NO_FREE    = 2'd2,
    ST_QUEUE_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic latch;
    logic rec_rd;
    logic scan_clr;
    logic scan_inc;
    logic res_invalid;
    logic res_no_free;
    logic create;
    logic wait_exec;
    logic release_exec;
    logic drain_step;
  } cst_cmd_t;

  typedef struct packed {
    op_t  op;
    logic idx_ok;
    logic scan_free;
    logic scan_last;
    logic fill_zero;
    logic drain_last;
    logic out_free;
  } cst_stat_t;

endpackage

>>> rtl/core/cst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ctrl
// Sequencer of the semaphore table: decode, slot scan, record update, drain.
// ----------------------------------------------------------------------------
module cst_ctrl
  import cst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  cst_stat_t stat,
  output cst_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_REC,
    S_DRAIN
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.op == OP_CREATE) begin
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN;
        end else if (!stat.idx_ok) begin
          if (stat.out_free) begin
            cmd.res_invalid = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.rec_rd = 1'b1;
          state_next = S_REC;
        end
      end
      S_SCAN: begin
        if (stat.scan_free) begin
          if (stat.out_free) begin
            cmd.create = 1'b1;
            state_next = S_IDLE;
          end
        end else if (stat.scan_last) begin
          if (stat.out_free) begin
            cmd.res_no_free = 1'b1;
            state_next      = S_IDLE;
          end
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_REC: begin
        if (stat.out_free) begin
          if (stat.op == OP_WAIT) begin
            cmd.wait_exec = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.release_exec = 1'b1;
            state_next       = stat.fill_zero ? S_IDLE : S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (stat.out_free) begin
          cmd.drain_step = 1'b1;
          if (stat.drain_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/cst_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_datapath
// Slot flags, slot record memory, waiter memory, drain pointers and the
// output register of the semaphore table.
// ----------------------------------------------------------------------------
module cst_datapath
  import cst_pkg::*;
#(
  parameter int NUM_SEMS    = NUM_SEMS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PID_BITS    = PID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  cst_cmd_t    cmd,
  output cst_stat_t   stat,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  localparam int SEM_BITS = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int Q_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QF_BITS  = $clog2(QUEUE_DEPTH + 1);
  localparam int HEAD_LO  = COUNT_BITS;
  localparam int FILL_LO  = COUNT_BITS + Q_BITS;
  localparam int REC_W    = COUNT_BITS + Q_BITS + QF_BITS;
  localparam int WQ_AW    = SEM_BITS + Q_BITS;
  localparam int WQ_DEPTH = NUM_SEMS << Q_BITS;

  op_t                 op_q;
  logic [3:0]          sem_q;
  logic [15:0]         init_q;
  logic [PID_BITS-1:0] pid_q;

  logic                in_use [NUM_SEMS];
  logic [SEM_BITS-1:0] scan;
  logic [SEM_BITS-1:0] slot;
  logic                idx_in_range;

  logic [REC_W-1:0]    rec_mem [NUM_SEMS];
  logic [REC_W-1:0]    rec_q;
  logic [REC_W-1:0]    rec_wdata;
  logic [SEM_BITS-1:0] rec_waddr;
  logic                rec_we;

  logic [COUNT_BITS-1:0] count_q;
  logic [Q_BITS-1:0]     head_q;
  logic [QF_BITS-1:0]    fill_q;
  logic                  count_zero;
  logic                  queue_full;
  logic [Q_BITS:0]       pos_sum;
  logic [Q_BITS-1:0]     pos_wrap;

  logic [PID_BITS-1:0] wq_mem [WQ_DEPTH];
  logic [PID_BITS-1:0] wq_q;
  logic                wq_we;
  logic                wq_re;
  logic [WQ_AW-1:0]    wq_raddr;

  logic [Q_BITS-1:0]  drain_pos;
  logic [QF_BITS-1:0] drain_left;
  logic [Q_BITS-1:0]  pos_adv;

  logic        out_valid;
  status_t     out_status;
  logic [3:0]  out_slot;
  logic        out_blocked;
  logic        out_woken;
  logic [7:0]  out_pid;
  logic        out_last;
  logic        out_free;

  assign slot         = SEM_BITS'(sem_q);
  assign idx_in_range = (32'(sem_q) < NUM_SEMS);

  assign count_q    = rec_q[COUNT_BITS-1:0];
  assign head_q     = rec_q[HEAD_LO +: Q_BITS];
  assign fill_q     = rec_q[FILL_LO +: QF_BITS];
  assign count_zero = (count_q == '0);
  assign queue_full = (fill_q >= QF_BITS'(QUEUE_DEPTH));

  // head plus fill, wrapped once around the ring
  assign pos_sum  = (Q_BITS + 1)'(head_q) + (Q_BITS + 1)'(fill_q);
  assign pos_wrap = (pos_sum >= (Q_BITS + 1)'(QUEUE_DEPTH))
                    ? Q_BITS'(pos_sum - (Q_BITS + 1)'(QUEUE_DEPTH))
                    : Q_BITS'(pos_sum);

  assign pos_adv = (drain_pos == Q_BITS'(QUEUE_DEPTH - 1)) ? '0 : drain_pos + 1'b1;

  assign out_free = !out_valid || m_tready;

  assign stat.op         = op_q;
  assign stat.idx_ok     = idx_in_range && in_use[slot];
  assign stat.scan_free  = !in_use[scan];
  assign stat.scan_last  = (scan == SEM_BITS'(NUM_SEMS - 1));
  assign stat.fill_zero  = (fill_q == '0);
  assign stat.drain_last = (drain_left == QF_BITS'(1));
  assign stat.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= op_t'(s_tuser[1:0]);
      sem_q  <= s_tdata[3:0];
      init_q <= s_tdata[19:4];
      pid_q  <= PID_BITS'(s_tdata[27:20]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      scan <= '0;
    end else if (cmd.scan_inc) begin
      scan <= scan + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SEMS; i++) begin
        in_use[i] <= 1'b0;
      end
    end else if (cmd.create) begin
      in_use[scan] <= 1'b1;
    end else if (cmd.release_exec && (op_q == OP_DESTROY)) begin
      in_use[slot] <= 1'b0;
    end
  end

  always_comb begin
    rec_wdata = rec_q;
    rec_we    = 1'b0;
    rec_waddr = slot;
    if (cmd.create) begin
      rec_we    = 1'b1;
      rec_waddr = scan;
      rec_wdata = {QF_BITS'(0), Q_BITS'(0), init_q};
    end else if (cmd.wait_exec) begin
      if (!count_zero) begin
        rec_we                       = 1'b1;
        rec_wdata[COUNT_BITS-1:0]    = count_q - 1'b1;
      end else if (!queue_full) begin
        rec_we                       = 1'b1;
        rec_wdata[FILL_LO +: QF_BITS] = fill_q + 1'b1;
      end
    end else if (cmd.release_exec) begin
      rec_we = 1'b1;
      if ((op_q == OP_POST) && (count_q != COUNT_MAX)) begin
        rec_wdata[COUNT_BITS-1:0] = count_q + 1'b1;
      end
      rec_wdata[HEAD_LO +: Q_BITS]  = pos_wrap;
      rec_wdata[FILL_LO +: QF_BITS] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    if (cmd.rec_rd) begin
      rec_q <= rec_mem[slot];
    end
  end

  assign wq_we    = cmd.wait_exec && count_zero && !queue_full;
  assign wq_re    = (cmd.release_exec && (fill_q != '0)) || cmd.drain_step;
  assign wq_raddr = cmd.release_exec ? {slot, head_q} : {slot, pos_adv};

  always_ff @(posedge clk) begin
    if (wq_we) begin
      wq_mem[{slot, pos_wrap}] <= pid_q;
    end
    if (wq_re) begin
      wq_q <= wq_mem[wq_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.release_exec) begin
      drain_pos  <= head_q;
      drain_left <= fill_q;
    end else if (cmd.drain_step) begin
      drain_pos  <= pos_adv;
      drain_left <= drain_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_invalid || cmd.res_no_free || cmd.create || cmd.wait_exec ||
                 (cmd.release_exec && (fill_q == '0)) || cmd.drain_step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_invalid) begin
      out_status  <= ST_INVALID;
      out_slot    <= sem_q;
      out_blocked <= 1'b0;
      out_woken   <= 1'b0;
      out_pid     <= '0;
      out_last    <= 1'b1;
    end else if (cmd.res_no_free) begin
      out_status  <= ST_NO_FREE;
      out_slot    <= '0;
      out_blocked <= 1'b0;
      out_woken   <= 1'b0;
      out_pid     <= '0;
      out_last    <= 1'b1;
    end else if (cmd.create) begin
      out_status  <= ST_OK;
      out_slot    <= 4'(scan);
      out_blocked <= 1'b0;
      out_woken   <= 1'b0;
      out_pid     <= '0;
      out_last    <= 1'b1;
    end else if (cmd.wait_exec) begin
      out_status  <= (count_zero && queue_full) ? ST_QUEUE_FULL : ST_OK;
      out_slot    <= sem_q;
      out_blocked <= count_zero && !queue_full;
      out_woken   <= 1'b0;
      out_pid     <= '0;
      out_last    <= 1'b1;
    end else if (cmd.release_exec) begin
      out_status  <= ST_OK;
      out_slot    <= sem_q;
      out_blocked <= 1'b0;
      out_woken   <= 1'b0;
      out_pid     <= '0;
      out_last    <= 1'b1;
    end else if (cmd.drain_step) begin
      out_status  <= ST_OK;
      out_slot    <= sem_q;
      out_blocked <= 1'b0;
      out_woken   <= 1'b1;
      out_pid     <= 8'(wq_q);
      out_last    <= (drain_left == QF_BITS'(1));
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_pid, out_slot, out_status};
  assign m_tuser  = {out_woken, out_blocked};
  assign m_tlast  = out_last;

endmodule

>>> rtl/core/counting_semaphore_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_table_unit
// Table of counting semaphores, each with a ring of waiting process ids.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one system call per item: op in s_tuser, slot, initial count
//   and caller id in s_tdata. m_* returns the result items; m_tlast marks the
//   final result of a call. Post and destroy return one result per released
//   waiter, oldest first, or a single result when no waiter is queued.
//   One call at a time; s_tready is high only while idle. An invalid slot is
//   answered from decode; wait, post and destroy read the slot record first,
//   and post or destroy with waiters also read the waiter memory before the
//   first result; create scans the slots from 0 for the lowest free one.
//   Released waiters follow one per cycle while the receiver keeps m_tready
//   high, paced by the read port of the waiter memory. The sequencer returns
//   to idle as it registers the last result of a call.
//   The output register holds a result until m_tready; a stalled receiver
//   holds the sequencer before its next result and, after that, s_tready.
//   Reset clears the slot flags and the output valid; a call may be sent as
//   soon as reset is released.
// ----------------------------------------------------------------------------
module counting_semaphore_table_unit
  import cst_pkg::*;
#(
  parameter int NUM_SEMS    = NUM_SEMS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PID_BITS    = PID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sem_index[3:0], initial_count[19:4], caller_pid[27:20]
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // status[1:0], slot_out[5:2], woken_pid[13:6]
  output logic [1:0]  m_tuser,   // blocked[0], woken_valid[1]
  output logic        m_tlast    // last
);

  cst_cmd_t  cmd;
  cst_stat_t stat;

  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cst_datapath #(
    .NUM_SEMS    (NUM_SEMS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_BITS    (PID_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> test/counting_semaphore_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_table_unit_tb
// Self-checking bench for the counting semaphore table unit. A scoreboard
// class keeps its own copy of the slot table and wait rings. It predicts the
// result items of every accepted call and checks each returned item in order.
// The stimulus starts with directed calls. It then fills the table and
// overflows one wait ring, then drains it while the receiver holds off for a long stretch.
// The rest is random call sequences aimed at live slots, with some noise.
// ----------------------------------------------------------------------------
module counting_semaphore_table_unit_tb;
  import cst_pkg::*;

  localparam int NUM_SEMS     = NUM_SEMS_DEF;
  localparam int QUEUE_DEPTH  = QUEUE_DEPTH_DEF;
  localparam int RANDOM_CALLS = 192;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    status_t    status;
    logic [3:0] slot;
    logic       blocked;
    logic       woken_valid;
    logic [7:0] woken_pid;
    logic       last;
  } sem_result_t;

  class sem_table_scoreboard;
    bit          in_use [NUM_SEMS];
    logic [15:0] count  [NUM_SEMS];
    logic [7:0]  ring   [NUM_SEMS][QUEUE_DEPTH];
    int          head   [NUM_SEMS];
    int          fill   [NUM_SEMS];
    sem_result_t pending_results[$];
    int          mismatch_count;

    function new();
      for (int s = 0; s < NUM_SEMS; s++) begin
        in_use[s] = 1'b0;
        count[s]  = '0;
        head[s]   = 0;
        fill[s]   = 0;
      end
      mismatch_count = 0;
    endfunction

    function void add_result(status_t st, int slot, bit blk, bit wv, logic [7:0] pid, bit last);
      sem_result_t r;
      r.status      = st;
      r.slot        = 4'(slot);
      r.blocked     = blk;
      r.woken_valid = wv;
      r.woken_pid   = pid;
      r.last        = last;
      pending_results.push_back(r);
    endfunction

    function void release_waiters(int s);
      int n;
      n = fill[s];
      if (n == 0) add_result(ST_OK, s, 1'b0, 1'b0, 8'h00, 1'b1);
      for (int i = 0; i < n; i++) begin
        add_result(ST_OK, s, 1'b0, 1'b1, ring[s][(head[s] + i) % QUEUE_DEPTH], i == n - 1);
      end
      head[s] = (head[s] + n) % QUEUE_DEPTH;
      fill[s] = 0;
    endfunction

    function void note_call(op_t op, logic [3:0] idx, logic [15:0] init, logic [7:0] pid);
      int s;
      int free_slot;
      s = idx;
      if (op == OP_CREATE) begin
        free_slot = -1;
        for (int i = NUM_SEMS - 1; i >= 0; i--) begin
          if (!in_use[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          add_result(ST_NO_FREE, 0, 1'b0, 1'b0, 8'h00, 1'b1);
        end else begin
          in_use[free_slot] = 1'b1;
          count[free_slot]  = init;
          head[free_slot]   = 0;
          fill[free_slot]   = 0;
          add_result(ST_OK, free_slot, 1'b0, 1'b0, 8'h00, 1'b1);
        end
        return;
      end
      if (s >= NUM_SEMS || !in_use[s]) begin
        add_result(ST_INVALID, s, 1'b0, 1'b0, 8'h00, 1'b1);
        return;
      end
      case (op)
        OP_WAIT: begin
          if (count[s] != 16'd0) begin
            count[s] = count[s] - 16'd1;
            add_result(ST_OK, s, 1'b0, 1'b0, 8'h00, 1'b1);
          end else if (fill[s] >= QUEUE_DEPTH) begin
            add_result(ST_QUEUE_FULL, s, 1'b0, 1'b0, 8'h00, 1'b1);
          end else begin
            ring[s][(head[s] + fill[s]) % QUEUE_DEPTH] = pid;
            fill[s]++;
            add_result(ST_OK, s, 1'b1, 1'b0, 8'h00, 1'b1);
          end
        end
        OP_POST: begin
          if (count[s] != COUNT_MAX) count[s] = count[s] + 16'd1;
          release_waiters(s);
        end
        default: begin
          in_use[s] = 1'b0;
          release_waiters(s);
        end
      endcase
    endfunction

    function void check_result(sem_result_t got);
      sem_result_t want;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected result item: status=%0d slot=%0d blocked=%0b woken=%0b/%0d last=%0b",
                   got.status, got.slot, got.blocked, got.woken_valid, got.woken_pid, got.last);
        end
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.slot !== want.slot ||
          got.blocked !== want.blocked || got.woken_valid !== want.woken_valid ||
          got.woken_pid !== want.woken_pid || got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("result mismatch: want status=%0d slot=%0d blocked=%0b woken=%0b/%0d last=%0b",
                   want.status, want.slot, want.blocked, want.woken_valid, want.woken_pid,
                   want.last);
          $display("                  got status=%0d slot=%0d blocked=%0b woken=%0b/%0d last=%0b",
                   got.status, got.slot, got.blocked, got.woken_valid, got.woken_pid, got.last);
        end
      end
    endfunction

    function int used_count();
      int n;
      n = 0;
      for (int s = 0; s < NUM_SEMS; s++) n += in_use[s];
      return n;
    endfunction

    function int pick_used_slot();
      int used[$];
      for (int s = 0; s < NUM_SEMS; s++) begin
        if (in_use[s]) used.push_back(s);
      end
      if (used.size() == 0) return -1;
      return used[$urandom_range(0, used.size() - 1)];
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;    // sem_index[3:0], initial_count[19:4], caller_pid[27:20]
  logic [1:0]  s_tuser = '0;    // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // status[1:0], slot_out[5:2], woken_pid[13:6]
  logic [1:0]  m_tuser;         // blocked[0], woken_valid[1]
  logic        m_tlast;

  sem_table_scoreboard sem_sb;
  int calls_sent = 0;
  int idle_cycles = 0;
  int rx_hold_left = 0;
  bit rx_steady = 1'b0;
  bit tx_steady = 1'b0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;

  counting_semaphore_table_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      m_tready     <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (long_hold_req && !long_hold_done) begin
      m_tready       <= 1'b0;
      rx_hold_left   <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (!rx_steady && $urandom_range(0, 99) < 30) begin
      m_tready     <= 1'b0;
      rx_hold_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                   : $urandom_range(8, 30);
    end else begin
      m_tready <= 1'b1;
    end
    if ($urandom_range(0, 149) == 0) rx_steady <= !rx_steady;
  end

  always @(posedge clk) begin : result_monitor
    sem_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status      = status_t'(m_tdata[1:0]);
      got.slot        = m_tdata[5:2];
      got.woken_pid   = m_tdata[13:6];
      got.blocked     = m_tuser[0];
      got.woken_valid = m_tuser[1];
      got.last        = m_tlast;
      sem_sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'd0;
    if (r < 60) return 16'($urandom_range(1, 3));
    if (r < 70) return COUNT_MAX;
    if (r < 75) return COUNT_MAX - 16'd1;
    return 16'($urandom);
  endfunction

  task automatic sender_pause();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 45) n = 0;
    else if (r < 88) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n != 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_call(op_t op, logic [3:0] idx, logic [15:0] init, logic [7:0] pid);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, pid, init, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sem_sb.note_call(op, idx, init, pid);
    calls_sent++;
    sender_pause();
  endtask

  task automatic fill_table();
    while (sem_sb.used_count() < NUM_SEMS) begin
      send_call(OP_CREATE, 4'($urandom), pick_count(), 8'($urandom));
    end
    repeat ($urandom_range(1, 2)) send_call(OP_CREATE, 4'($urandom), pick_count(), 8'($urandom));
  endtask

  function automatic logic [3:0] pick_target();
    int s;
    s = sem_sb.pick_used_slot();
    if (s < 0 || $urandom_range(0, 99) < 10) return 4'($urandom);
    return 4'(s);
  endfunction

  initial begin : stimulus
    int r;
    int directed_calls;
    logic [3:0] s;
    sem_sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_call(OP_CREATE,  4'd9,  16'd0,      8'hFF);
    send_call(OP_CREATE,  4'd0,  16'hFFFF,   8'h00);
    send_call(OP_WAIT,    4'd0,  16'hFFFF,   8'hFF);
    send_call(OP_WAIT,    4'd0,  16'd0,      8'h00);
    send_call(OP_WAIT,    4'd1,  16'd0,      8'h5A);
    send_call(OP_POST,    4'd1,  16'd0,      8'h00);
    send_call(OP_POST,    4'd1,  16'd0,      8'h00);
    send_call(OP_POST,    4'd0,  16'h0000,   8'hFF);
    send_call(OP_WAIT,    4'd0,  16'd0,      8'h3C);
    send_call(OP_WAIT,    4'd0,  16'd0,      8'hA5);
    send_call(OP_DESTROY, 4'd0,  16'd0,      8'h00);
    send_call(OP_DESTROY, 4'd0,  16'd0,      8'h00);
    send_call(OP_WAIT,    4'd15, 16'hFFFF,   8'hFF);
    send_call(OP_POST,    4'd7,  16'd0,      8'h00);
    send_call(OP_DESTROY, 4'd1,  16'd0,      8'h00);
    send_call(OP_CREATE,  4'd15, 16'h8001,   8'h81);
    send_call(OP_WAIT,    4'd0,  16'd0,      8'h7E);
    send_call(OP_DESTROY, 4'd0,  16'd0,      8'h00);
    directed_calls = calls_sent;

    // Fill the table, reopen one slot at zero and overflow its wait ring.
    fill_table();
    send_call(OP_DESTROY, 4'd3, 16'd0, 8'h00);
    send_call(OP_CREATE, 4'($urandom), 16'd0, 8'($urandom));
    repeat (QUEUE_DEPTH + 2) send_call(OP_WAIT, 4'd3, 16'($urandom), 8'($urandom));
    long_hold_req <= 1'b1;
    send_call(OP_POST, 4'd3, 16'($urandom), 8'($urandom));

    while (calls_sent - directed_calls < RANDOM_CALLS) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) tx_steady = !tx_steady;
      if (r < 8) begin
        fill_table();
      end else if (r < 22) begin
        if (sem_sb.used_count() == 0) begin
          send_call(OP_CREATE, 4'($urandom), 16'd0, 8'($urandom));
        end
        s = 4'(sem_sb.pick_used_slot());
        repeat ($urandom_range(1, 20)) send_call(OP_WAIT, s, 16'($urandom), 8'($urandom));
        if ($urandom_range(0, 99) < 60) begin
          send_call(($urandom_range(0, 3) == 0) ? OP_DESTROY : OP_POST, s,
                    16'($urandom), 8'($urandom));
        end
      end else if (r < 32) begin
        repeat ($urandom_range(1, 6)) send_call(OP_DESTROY, pick_target(), 16'($urandom),
                                                8'($urandom));
      end else if (r < 85) begin
        r = $urandom_range(0, 99);
        if (r < 40) send_call(OP_WAIT, pick_target(), 16'($urandom), 8'($urandom));
        else if (r < 70) send_call(OP_POST, pick_target(), 16'($urandom), 8'($urandom));
        else if (r < 80) send_call(OP_DESTROY, pick_target(), 16'($urandom), 8'($urandom));
        else send_call(OP_CREATE, 4'($urandom), pick_count(), 8'($urandom));
      end else begin
        send_call(op_t'($urandom_range(0, 3)), 4'($urandom), 16'($urandom), 8'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    while (sem_sb.pending_results.size() != 0) @(posedge clk);
    repeat (NUM_SEMS + 24) @(posedge clk);
    if (sem_sb.mismatch_count == 0 && sem_sb.pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/cst_pkg.sv
rtl/core/cst_ctrl.sv
rtl/core/cst_datapath.sv
rtl/core/counting_semaphore_table_unit.sv
test/counting_semaphore_table_unit_tb.sv
